// ===== design/textured_quad_clip_rotate_emitter_unit_macros.svh =====
// Assertion macros used by the quad emitter controller.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef TEXTURED_QUAD_CLIP_ROTATE_EMITTER_UNIT_MACROS_SVH
`define TEXTURED_QUAD_CLIP_ROTATE_EMITTER_UNIT_MACROS_SVH

// same-cycle implication
`define TQCR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TQCR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tqcr_pkg.sv =====
// Types, constants and helpers for the textured quad clip/rotate emitter.
// No dependencies.
package tqcr_pkg;

    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 128;
    localparam int CFG_W       = 64;
    localparam int TEX_W       = 40;
    localparam int PROD_W      = 34;
    localparam int DIVD_W      = 34;
    localparam int DVSR_W      = 16;

    localparam logic [2:0] CFG_COLOR   = 3'd0;
    localparam logic [2:0] CFG_DEPTH   = 3'd1;
    localparam logic [2:0] CFG_CLIP_EN = 3'd2;
    localparam logic [2:0] CFG_BOUNDS  = 3'd3;
    localparam logic [2:0] CFG_ROT_EN  = 3'd4;
    localparam logic [2:0] CFG_COS_SIN = 3'd5;
    localparam logic [2:0] CFG_CENTER  = 3'd6;
    localparam logic [2:0] CFG_ASPECT  = 3'd7;

    localparam logic [1:0] EDGE_X0 = 2'd0;
    localparam logic [1:0] EDGE_Y0 = 2'd1;
    localparam logic [1:0] EDGE_X1 = 2'd2;
    localparam logic [1:0] EDGE_Y1 = 2'd3;

    localparam logic [2:0] VTX_LAST = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_CLIP_CHK, ST_CLIP_MUL, ST_DIV_START, ST_DIV_WAIT,
        ST_CLIP_APPLY, ST_VSEL, ST_ROT1, ST_ROT2, ST_ROT3, ST_ROT4, ST_EMIT
    } state_t;

    typedef struct packed {
        logic       cap;
        logic [1:0] edge_sel;
        logic       hi_phase;
        logic       mul_ld;
        logic       div_start;
        logic       apply;
        logic [2:0] vsel;
        logic       rot1;
        logic       rot2;
        logic       rot3;
        logic       rot4;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic clip_en;
        logic rot_en;
        logic reject;
        logic need;
        logic nz;
        logic cnt_full;
        logic cnt_last;
        logic out_free;
        logic div_done;
    } status_t;

    function automatic logic signed [15:0] sat16(input logic signed [TEX_W-1:0] v);
        logic signed [15:0] r;
        if (v > 40'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -40'sd32768) begin
            r = -16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ===== design/tqcr_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned.
// Uses tqcr_pkg widths.
module tqcr_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [tqcr_pkg::DIVD_W-1:0] dividend,
    input  logic [tqcr_pkg::DVSR_W-1:0] divisor,
    output logic                        busy,
    output logic [tqcr_pkg::DIVD_W-1:0] quotient
);
    import tqcr_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVSR_W:0]  rem_reg, rem_next;
    logic [DIVD_W-1:0] dq_reg, dq_next;
    logic [DVSR_W-1:0] dvsr_reg, dvsr_next;
    logic [DVSR_W:0]  sh;
    logic [DVSR_W+1:0] trial;

    always_comb begin
        sh        = {rem_reg[DVSR_W-1:0], dq_reg[DIVD_W-1]};
        trial     = {1'b0, sh} - {2'b00, dvsr_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        dvsr_next = dvsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dq_next   = dividend;
            dvsr_next = divisor;
        end else if (busy_reg) begin
            rem_next = trial[DVSR_W+1] ? sh : trial[DVSR_W:0];
            dq_next  = {dq_reg[DIVD_W-2:0], ~trial[DVSR_W+1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIVD_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        dq_reg   <= dq_next;
        dvsr_reg <= dvsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = dq_reg;

endmodule

// ===== design/tqcr_dp.sv =====
// Datapath: config registers, quad registers, clip arithmetic, rotation,
// vertex counter and output register. Uses tqcr_pkg and tqcr_div.
module tqcr_dp #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [2:0]                       cfg_addr,
    input  logic [tqcr_pkg::CFG_W-1:0]       cfg_wr_data,
    input  logic [tqcr_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tuser,
    input  tqcr_pkg::cmd_t                   cmd,
    output tqcr_pkg::status_t                sts,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tqcr_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                             m_tlast
);
    import tqcr_pkg::*;

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    // configuration
    logic [31:0] color_reg;
    logic [15:0] depth_reg;
    logic        clip_en_reg;
    logic [63:0] bounds_reg;
    logic        rot_en_reg;
    logic [31:0] cos_sin_reg;
    logic [31:0] center_reg;
    logic [31:0] aspect_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg   <= 32'hFFFF_FFFF;
            depth_reg   <= '0;
            clip_en_reg <= 1'b0;
            bounds_reg  <= '0;
            rot_en_reg  <= 1'b0;
            cos_sin_reg <= 32'h0000_4000;
            center_reg  <= '0;
            aspect_reg  <= 32'h1000_1000;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_COLOR:   color_reg   <= cfg_wr_data[31:0];
                CFG_DEPTH:   depth_reg   <= cfg_wr_data[15:0];
                CFG_CLIP_EN: clip_en_reg <= cfg_wr_data[0];
                CFG_BOUNDS:  bounds_reg  <= cfg_wr_data;
                CFG_ROT_EN:  rot_en_reg  <= cfg_wr_data[0];
                CFG_COS_SIN: cos_sin_reg <= cfg_wr_data[31:0];
                CFG_CENTER:  center_reg  <= cfg_wr_data[31:0];
                CFG_ASPECT:  aspect_reg  <= cfg_wr_data[31:0];
                default: ;
            endcase
        end
    end

    logic signed [15:0] xmin, ymin, xmax, ymax, cs, sn, cx, cy;
    logic        [15:0] asp, rcp;
    assign xmin = bounds_reg[15:0];
    assign ymin = bounds_reg[31:16];
    assign xmax = bounds_reg[47:32];
    assign ymax = bounds_reg[63:48];
    assign cs   = cos_sin_reg[15:0];
    assign sn   = cos_sin_reg[31:16];
    assign cx   = center_reg[15:0];
    assign cy   = center_reg[31:16];
    assign asp  = aspect_reg[15:0];
    assign rcp  = aspect_reg[31:16];

    // quad state
    logic signed [15:0]      x0_reg, y0_reg, x1_reg, y1_reg;
    logic signed [TEX_W-1:0] u0_reg, v0_reg, u1_reg, v1_reg;
    logic signed [16:0]      du_reg, dx_reg, dv_reg, dy_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                    neg_reg;

    logic signed [15:0] in_lx, in_ty, in_lu, in_tv, in_rx, in_by, in_ru, in_bv;
    assign in_lx = s_tdata[15:0];
    assign in_ty = s_tdata[31:16];
    assign in_lu = s_tdata[47:32];
    assign in_tv = s_tdata[63:48];
    assign in_rx = s_tdata[79:64];
    assign in_by = s_tdata[95:80];
    assign in_ru = s_tdata[111:96];
    assign in_bv = s_tdata[127:112];

    // edge selection
    logic signed [15:0]      c_sel, lo_sel, hi_sel;
    logic signed [TEX_W-1:0] t_sel;
    logic signed [16:0]      dtex, dspan, diff;

    always_comb begin
        case (cmd.edge_sel)
            EDGE_X0: begin
                c_sel = x0_reg; t_sel = u0_reg; dtex = du_reg; dspan = dx_reg;
                lo_sel = xmin; hi_sel = xmax;
            end
            EDGE_Y0: begin
                c_sel = y0_reg; t_sel = v0_reg; dtex = dv_reg; dspan = dy_reg;
                lo_sel = ymin; hi_sel = ymax;
            end
            EDGE_X1: begin
                c_sel = x1_reg; t_sel = u1_reg; dtex = du_reg; dspan = dx_reg;
                lo_sel = xmin; hi_sel = xmax;
            end
            default: begin
                c_sel = y1_reg; t_sel = v1_reg; dtex = dv_reg; dspan = dy_reg;
                lo_sel = ymin; hi_sel = ymax;
            end
        endcase
        diff = cmd.hi_phase ? (17'(c_sel) - 17'(hi_sel)) : (17'(lo_sel) - 17'(c_sel));
    end

    // division
    logic [PROD_W-1:0] prod_mag;
    logic [16:0]       span_mag;
    logic [DIVD_W-1:0] dividend, quotient;
    logic              div_busy;

    assign prod_mag = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign span_mag = dspan[16] ? 17'(-dspan) : 17'(dspan);
    assign dividend = DIVD_W'(prod_mag) + DIVD_W'(span_mag[16:1]);

    tqcr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (span_mag[DVSR_W-1:0]),
        .busy     (div_busy),
        .quotient (quotient)
    );

    logic signed [TEX_W-1:0] q_s, t_new;
    logic signed [15:0]      c_new;
    always_comb begin
        q_s = neg_reg ? -signed'(TEX_W'(quotient)) : signed'(TEX_W'(quotient));
        if (dspan == 17'sd0) begin
            t_new = t_sel;
        end else if (cmd.hi_phase) begin
            t_new = t_sel - q_s;
        end else begin
            t_new = t_sel + q_s;
        end
        c_new = cmd.hi_phase ? hi_sel : lo_sel;
    end

    // vertex selection and rotation
    logic signed [15:0]      xv, yv;
    logic signed [TEX_W-1:0] uv, vv;
    logic                    use_x1, use_y1;
    always_comb begin
        use_x1 = (cmd.vsel == 3'd1) || (cmd.vsel == 3'd2) || (cmd.vsel == 3'd5);
        use_y1 = (cmd.vsel == 3'd1) || (cmd.vsel == 3'd4) || (cmd.vsel == 3'd5);
        xv = use_x1 ? x1_reg : x0_reg;
        uv = use_x1 ? u1_reg : u0_reg;
        yv = use_y1 ? y1_reg : y0_reg;
        vv = use_y1 ? v1_reg : v0_reg;
    end

    logic signed [16:0] dxd, dyd, asp_s, rcp_s;
    logic signed [32:0] pxc_reg, pxs_reg;
    logic signed [33:0] yr_reg;
    logic signed [49:0] pyc_reg, pys_reg;
    logic signed [51:0] x2, y2;
    logic signed [26:0] xrot_reg;
    logic signed [37:0] y2r_reg;
    logic signed [54:0] m_reg;
    logic signed [54:0] m_rnd;
    logic signed [31:0] yrot;
    logic signed [51:0] x2_rnd, y2_rnd;

    assign dxd   = 17'(xv) - 17'(cx);
    assign dyd   = 17'(yv) - 17'(cy);
    assign asp_s = signed'({1'b0, asp});
    assign rcp_s = signed'({1'b0, rcp});
    assign x2     = (52'(pxc_reg) <<< 12) - 52'(pys_reg);
    assign y2     = (52'(pxs_reg) <<< 12) + 52'(pyc_reg);
    assign x2_rnd = x2 + (52'sd1 <<< 25);
    assign y2_rnd = y2 + (52'sd1 <<< 13);
    assign m_rnd  = m_reg + (55'sd1 <<< 23);
    assign yrot   = 32'(cy) + 32'(m_rnd >>> 24);

    // vertex counter
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W+9:0]   slot_ext;
    assign slot_ext = {10'b0, cnt_reg};

    // output register
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_last_reg;
    logic                   out_free;
    logic signed [15:0]     ox, oy;

    assign out_free = !out_valid_reg || m_tready;
    assign ox = rot_en_reg ? sat16(TEX_W'(xrot_reg)) : xv;
    assign oy = rot_en_reg ? sat16(TEX_W'(yrot)) : yv;

    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            x0_reg <= in_lx;
            y0_reg <= in_ty;
            x1_reg <= in_rx;
            y1_reg <= in_by;
            u0_reg <= TEX_W'(in_lu);
            v0_reg <= TEX_W'(in_tv);
            u1_reg <= TEX_W'(in_ru);
            v1_reg <= TEX_W'(in_bv);
            du_reg <= 17'(in_ru) - 17'(in_lu);
            dx_reg <= 17'(in_rx) - 17'(in_lx);
            dv_reg <= 17'(in_bv) - 17'(in_tv);
            dy_reg <= 17'(in_by) - 17'(in_ty);
        end else if (cmd.apply) begin
            case (cmd.edge_sel)
                EDGE_X0: begin x0_reg <= c_new; u0_reg <= t_new; end
                EDGE_Y0: begin y0_reg <= c_new; v0_reg <= t_new; end
                EDGE_X1: begin x1_reg <= c_new; u1_reg <= t_new; end
                default: begin y1_reg <= c_new; v1_reg <= t_new; end
            endcase
        end
        if (cmd.mul_ld) begin
            prod_reg <= dtex * diff;
        end
        if (cmd.div_start) begin
            neg_reg <= prod_reg[PROD_W-1] ^ dspan[16];
        end
        if (cmd.rot1) begin
            pxc_reg <= dxd * cs;
            pxs_reg <= dxd * sn;
            yr_reg  <= dyd * asp_s;
        end
        if (cmd.rot2) begin
            pyc_reg <= yr_reg * cs;
            pys_reg <= yr_reg * sn;
        end
        if (cmd.rot3) begin
            xrot_reg <= 27'(cx) + 27'(x2_rnd >>> 26);
            y2r_reg  <= 38'(y2_rnd >>> 14);
        end
        if (cmd.rot4) begin
            m_reg <= y2r_reg * rcp_s;
        end
        if (cmd.emit) begin
            out_data_reg <= {6'b0, color_reg, sat16(vv), sat16(uv), depth_reg, oy, ox,
                             slot_ext[9:0]};
            out_last_reg <= (cmd.vsel == VTX_LAST) || (cnt_reg == CNT_W'(MAX_VERTICES - 1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.cap && s_tuser) begin
                cnt_reg <= '0;
            end else if (cmd.emit) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        sts.clip_en  = clip_en_reg;
        sts.rot_en   = rot_en_reg;
        sts.reject   = (x1_reg < xmin) || (x0_reg >= xmax) || (y0_reg < ymin) || (y1_reg >= ymax);
        sts.need     = !diff[16] && (diff != 17'sd0);
        sts.nz       = dspan != 17'sd0;
        sts.cnt_full = cnt_reg == CNT_W'(MAX_VERTICES);
        sts.cnt_last = cnt_reg == CNT_W'(MAX_VERTICES - 1);
        sts.out_free = out_free;
        sts.div_done = !div_busy;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== design/tqcr_ctrl.sv =====
// Controller FSM: sequences capture, edge clipping, rotation and emission.
// Uses tqcr_pkg and the assertion macros header.
`include "textured_quad_clip_rotate_emitter_unit_macros.svh"

module tqcr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  tqcr_pkg::status_t   sts_i,
    output tqcr_pkg::cmd_t      cmd_o
);
    import tqcr_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] edge_reg, edge_next;
    logic       hi_reg, hi_next;
    logic [2:0] k_reg, k_next;

    always_comb begin
        state_next = state_reg;
        edge_next  = edge_reg;
        hi_next    = hi_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                edge_next = EDGE_X0;
                hi_next   = 1'b0;
                k_next    = '0;
                if (sts_i.clip_en && sts_i.reject) state_next = ST_IDLE;
                else if (sts_i.clip_en)            state_next = ST_CLIP_CHK;
                else                               state_next = ST_VSEL;
            end
            ST_CLIP_CHK, ST_CLIP_APPLY: begin
                if (state_reg == ST_CLIP_CHK && sts_i.need) begin
                    state_next = sts_i.nz ? ST_CLIP_MUL : ST_CLIP_APPLY;
                end else if (!hi_reg) begin
                    hi_next    = 1'b1;
                    state_next = ST_CLIP_CHK;
                end else begin
                    hi_next = 1'b0;
                    if (edge_reg == EDGE_Y1) begin
                        state_next = ST_VSEL;
                    end else begin
                        edge_next  = edge_reg + 1'b1;
                        state_next = ST_CLIP_CHK;
                    end
                end
            end
            ST_CLIP_MUL:  state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (sts_i.div_done) state_next = ST_CLIP_APPLY;
            end
            ST_VSEL: begin
                if (sts_i.cnt_full)    state_next = ST_IDLE;
                else if (sts_i.rot_en) state_next = ST_ROT1;
                else                   state_next = ST_EMIT;
            end
            ST_ROT1: state_next = ST_ROT2;
            ST_ROT2: state_next = ST_ROT3;
            ST_ROT3: state_next = ST_ROT4;
            ST_ROT4: state_next = ST_EMIT;
            ST_EMIT: begin
                if (sts_i.out_free) begin
                    if (k_reg == VTX_LAST || sts_i.cnt_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_VSEL;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready        = state_reg == ST_IDLE;
        cmd_o           = '0;
        cmd_o.edge_sel  = edge_reg;
        cmd_o.hi_phase  = hi_reg;
        cmd_o.vsel      = k_reg;
        cmd_o.cap       = (state_reg == ST_IDLE) && s_tvalid;
        cmd_o.mul_ld    = state_reg == ST_CLIP_MUL;
        cmd_o.div_start = state_reg == ST_DIV_START;
        cmd_o.apply     = state_reg == ST_CLIP_APPLY;
        cmd_o.rot1      = state_reg == ST_ROT1;
        cmd_o.rot2      = state_reg == ST_ROT2;
        cmd_o.rot3      = state_reg == ST_ROT3;
        cmd_o.rot4      = state_reg == ST_ROT4;
        cmd_o.emit      = (state_reg == ST_EMIT) && sts_i.out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            edge_reg  <= EDGE_X0;
            hi_reg    <= 1'b0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            edge_reg  <= edge_next;
            hi_reg    <= hi_next;
            k_reg     <= k_next;
        end
    end

    `TQCR_ASSERT_IMP(a_emit_free, cmd_o.emit, sts_i.out_free, "emit into occupied output")
    `TQCR_ASSERT_NXT(a_cap_check, cmd_o.cap, state_reg == ST_CHECK, "capture not followed by check")
    `TQCR_ASSERT_NXT(a_div_apply, (state_reg == ST_DIV_WAIT) && sts_i.div_done, state_reg == ST_CLIP_APPLY, "division result not applied")

endmodule

// ===== design/textured_quad_clip_rotate_emitter_unit.sv =====
// A new quad is taken only in idle, after the last one is done. Each clip division uses
// an iterative divider (one bit per cycle, up to 8 divisions per quad).
// Rotation adds multiplier steps before each vertex is emitted; a vertex waits while
// the output register is full. With clip on, each edge is checked on its low and high
// side; a clamp with zero span skips the divider. A rejected quad goes back to idle.
// Reset: synchronous active-low aresetn; config to defaults, vertex counter cleared.
module textured_quad_clip_rotate_emitter_unit #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [2:0]                       cfg_addr,
    input  logic [tqcr_pkg::CFG_W-1:0]       cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // left_x, top_y, left_u, top_v, right_x, bottom_y, right_u, bottom_v
    input  logic [tqcr_pkg::IN_TDATA_W-1:0]  s_tdata,
    // new_batch
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // vertex_slot, out_x, out_y, out_depth, out_u, out_v, out_color, zero pad
    output logic [tqcr_pkg::OUT_TDATA_W-1:0] m_tdata,
    // last_vertex
    output logic                             m_tlast
);
    import tqcr_pkg::*;

    cmd_t    cmd;
    status_t sts;

    tqcr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts_i    (sts),
        .cmd_o    (cmd)
    );

    tqcr_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule
